// ===== sv/length_prefixed_reassembler_core_assert.svh =====
// Assertion macros for the length-prefixed reassembler core.
`ifndef LENGTH_PREFIXED_REASSEMBLER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_REASSEMBLER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define LPR_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("reassembler assertion failed");
`define LPR_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("reassembler reset assertion failed");
`else
`define LPR_ASSERT(name, prop)
`define LPR_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== sv/lpr_pkg.sv =====
// Package with the types and constants of the length-prefixed reassembler.
`timescale 1ns / 1ps

package lpr_pkg;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'b0001,
      PH_LEN_HIGH = 4'b0010,
      PH_PAYLOAD  = 4'b0100,
      PH_DRAIN    = 4'b1000
   } phase_type;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
   localparam logic [2:0] KIND_COMPLETE   = 3'd1;
   localparam logic [2:0] KIND_TIMEOUT    = 3'd2;
   localparam logic [2:0] KIND_BAD_LENGTH = 3'd3;
   localparam logic [2:0] KIND_SHORT      = 3'd4;

   localparam logic CSR_TIMEOUT_LIMIT = 1'b0;
   localparam logic CSR_MTU_SIZE      = 1'b1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [9:0]  MTU_RESET     = 10'd23;
   localparam logic [9:0]  MTU_LOW       = 10'd23;
   localparam logic [9:0]  MTU_HIGH      = 10'd517;
   localparam logic [9:0]  MTU_MIN_FRAME = 10'd2;
   localparam logic [15:0] TICK_MAX      = 16'hFFFF;
   localparam logic [12:0] LEN_SAT       = 13'h1FFF;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
      logic       frag_last;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  kind;
      logic [7:0]  out_byte;
      logic [12:0] msg_length;
   } result_type;

endpackage

// ===== sv/lpr_ctrl.sv =====
// Reassembly state, configuration registers and per-request result logic.
`timescale 1ns / 1ps

module lpr_ctrl #(
   parameter int MAX_MESSAGE = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [15:0]        csr_data,
   input  logic               step,
   input  lpr_pkg::item_type  item,
   output lpr_pkg::result_type res
);

   localparam logic [15:0] MAX_LEN = 16'(MAX_MESSAGE);

   lpr_pkg::phase_type phase_ff, phase_in;
   logic        at_start_ff, at_start_in;
   logic [7:0]  len_low_ff, len_low_in;
   logic [12:0] exp_len_ff, exp_len_in;
   logic [12:0] rcv_cnt_ff, rcv_cnt_in;
   logic [15:0] tick_ff, tick_in;
   logic [15:0] timeout_limit_ff;
   logic [9:0]  mtu_ff;

   logic [15:0] len_word;
   logic [15:0] tick_inc;
   logic [12:0] rcv_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_limit_ff <= lpr_pkg::TIMEOUT_RESET;
         mtu_ff           <= lpr_pkg::MTU_RESET;
      end else if (csr_write) begin
         if (csr_index == lpr_pkg::CSR_TIMEOUT_LIMIT) begin
            timeout_limit_ff <= csr_data;
         end else if (csr_data[9:0] >= lpr_pkg::MTU_LOW &&
                      csr_data[9:0] <= lpr_pkg::MTU_HIGH) begin
            mtu_ff <= csr_data[9:0];
         end
      end
   end

   always_comb begin
      len_word = {item.data_byte, len_low_ff};
      if (mtu_ff < lpr_pkg::MTU_MIN_FRAME) begin
         len_word = '0;
      end
      tick_inc = (tick_ff == lpr_pkg::TICK_MAX) ? tick_ff : tick_ff + 16'd1;
      rcv_inc  = rcv_cnt_ff + 13'd1;

      phase_in    = phase_ff;
      at_start_in = at_start_ff;
      len_low_in  = len_low_ff;
      exp_len_in  = exp_len_ff;
      rcv_cnt_in  = rcv_cnt_ff;
      tick_in     = tick_ff;
      res         = '0;

      if (step) begin
         if (item.func == lpr_pkg::FUNC_TICK) begin
            if (phase_ff == lpr_pkg::PH_LEN_HIGH || phase_ff == lpr_pkg::PH_PAYLOAD) begin
               tick_in = tick_inc;
               if (timeout_limit_ff != 16'd0 && tick_inc >= timeout_limit_ff) begin
                  res.valid  = 1'b1;
                  res.kind   = lpr_pkg::KIND_TIMEOUT;
                  phase_in   = at_start_ff ? lpr_pkg::PH_IDLE : lpr_pkg::PH_DRAIN;
                  exp_len_in = '0;
                  rcv_cnt_in = '0;
                  tick_in    = '0;
               end
            end
         end else begin
            case (phase_ff)
               lpr_pkg::PH_IDLE: begin
                  if (item.frag_last) begin
                     res.valid = 1'b1;
                     res.kind  = lpr_pkg::KIND_SHORT;
                  end else begin
                     len_low_in = item.data_byte;
                     tick_in    = '0;
                     phase_in   = lpr_pkg::PH_LEN_HIGH;
                  end
               end
               lpr_pkg::PH_LEN_HIGH: begin
                  if (len_word == 16'd0 || len_word > MAX_LEN) begin
                     res.valid      = 1'b1;
                     res.kind       = lpr_pkg::KIND_BAD_LENGTH;
                     res.msg_length = (len_word > 16'(lpr_pkg::LEN_SAT)) ?
                                      lpr_pkg::LEN_SAT : len_word[12:0];
                     exp_len_in     = '0;
                     phase_in       = item.frag_last ? lpr_pkg::PH_IDLE
                                                     : lpr_pkg::PH_DRAIN;
                  end else begin
                     exp_len_in = len_word[12:0];
                     rcv_cnt_in = '0;
                     phase_in   = item.frag_last ? lpr_pkg::PH_IDLE
                                                 : lpr_pkg::PH_PAYLOAD;
                  end
               end
               lpr_pkg::PH_PAYLOAD: begin
                  if (at_start_ff) begin
                     tick_in = '0;
                  end
                  res.valid    = 1'b1;
                  res.out_byte = item.data_byte;
                  if (rcv_inc >= exp_len_ff) begin
                     res.kind       = lpr_pkg::KIND_COMPLETE;
                     res.msg_length = exp_len_ff;
                     exp_len_in     = '0;
                     rcv_cnt_in     = '0;
                     phase_in       = item.frag_last ? lpr_pkg::PH_IDLE
                                                     : lpr_pkg::PH_DRAIN;
                  end else begin
                     res.kind   = lpr_pkg::KIND_PAYLOAD;
                     rcv_cnt_in = rcv_inc;
                  end
               end
               default: begin
                  if (item.frag_last) begin
                     phase_in = lpr_pkg::PH_IDLE;
                  end
               end
            endcase
            at_start_in = item.frag_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= lpr_pkg::PH_IDLE;
         at_start_ff <= 1'b1;
         len_low_ff  <= '0;
         exp_len_ff  <= '0;
         rcv_cnt_ff  <= '0;
         tick_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         at_start_ff <= at_start_in;
         len_low_ff  <= len_low_in;
         exp_len_ff  <= exp_len_in;
         rcv_cnt_ff  <= rcv_cnt_in;
         tick_ff     <= tick_in;
      end
   end

endmodule

// ===== sv/length_prefixed_reassembler_core.sv =====
// Top level of the length-prefixed reassembler: request and response registers.
`timescale 1ns / 1ps
// The block takes one request per cycle on the req_ channel while req_stall is low:
// a fragment byte with its end-of-fragment mark, or a timeout tick. Each request gives
// at most one response on the rsp_ channel: a payload byte, the completing byte with the
// message length, a timeout abort, a bad length or a short first fragment.
// An accepted request is held in the request register, is evaluated against the
// reassembly state and lands in the response register, from which its response is
// taken. Requests that give no response still take their turn in the request register.
// Throughput is one request per cycle while rsp_stall is low; the reassembly state
// is updated once per request.
// When the receiver raises rsp_stall, the response register holds and the request
// register fills; req_stall rises only while both are full and the response is stalled.
// Registers on the csr_ port are written by csr_write and should change only while idle.
// Synchronous reset empties both registers, returns the parser to waiting for a length
// prefix and loads the register reset values.

`include "length_prefixed_reassembler_core_assert.svh"

module length_prefixed_reassembler_core #(
   parameter int MAX_MESSAGE = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frag_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [12:0] rsp_msg_length,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   lpr_pkg::item_type   in_item_ff;
   logic                in_valid_ff, in_valid_in;
   lpr_pkg::result_type res;
   lpr_pkg::result_type rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;
   logic                step;
   logic                req_take;
   logic                rsp_abort;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = out_free ? (step && res.valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.func      <= req_func;
         in_item_ff.data_byte <= req_data_byte;
         in_item_ff.frag_last <= req_frag_last;
      end
      if (step) begin
         rsp_ff <= res;
      end
   end

   lpr_ctrl #(
      .MAX_MESSAGE(MAX_MESSAGE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .step      (step),
      .item      (in_item_ff),
      .res       (res)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_ff.kind;
   assign rsp_out_byte   = rsp_ff.out_byte;
   assign rsp_msg_length = rsp_ff.msg_length;

   assign rsp_abort = rsp_kind == lpr_pkg::KIND_TIMEOUT || rsp_kind == lpr_pkg::KIND_SHORT;

   `LPR_ASSERT(a_req_held, req_valid && !req_stall |=> in_valid_ff)
   `LPR_ASSERT(a_kind_legal, rsp_valid |-> rsp_kind <= lpr_pkg::KIND_SHORT)
   `LPR_ASSERT(a_no_byte_on_abort, rsp_valid && rsp_abort |-> rsp_out_byte == 8'd0 && rsp_msg_length == 13'd0)
   `LPR_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid && !req_stall)

endmodule
